// ===== sv/connection_idle_timeout_table_unit_macros.svh =====
// Assertion macros for the connection aging table
`ifndef CONNECTION_IDLE_TIMEOUT_TABLE_UNIT_MACROS_SVH
`define CONNECTION_IDLE_TIMEOUT_TABLE_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define CITT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define CITT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== sv/citt_pkg.sv =====
// ----------------------------------------------------------------------------
// citt_pkg
// Types and codes shared by the connection aging table.
// ----------------------------------------------------------------------------
package citt_pkg;
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_PAUSE  = 2'd2;
	localparam logic [1:0] MODE_SWEEP  = 2'd3;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_REFRESH  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_DONE     = 3'd3;
	localparam logic [2:0] ST_ABSENT   = 3'd4;
	localparam logic [2:0] ST_EXPIRED  = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_MAX     = 1'b1;
endpackage

// ===== sv/connection_idle_timeout_table_unit.sv =====
// Add, remove and pause give one result, after the FIND and APPLY states.
// Sweep gives expired ids one at a time, oldest first, then ends.
// A new command is taken only when the unit is idle (busy low).
// The row of cells compares every entry in parallel; on a drop the entries behind it shift one step.
// Reset clears all valid bits and the count at once; no clearing pass.
// Results cannot be stalled.
module connection_idle_timeout_table_unit #(
	parameter int CAPACITY = 32,
	parameter int ID_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] conn_id,
	input  logic [31:0] now_seconds,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] result_id,
	output logic [5:0]  occupancy,
	output logic        last
);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {S_IDLE, S_FIND, S_APPLY, S_SWEEP, S_EMIT} state_t;
	state_t state_q;

	logic [15:0]        timeout_q;
	logic [5:0]         max_q;
	logic [1:0]         mode_q;
	logic [ID_BITS-1:0] key_q;
	logic [15:0]        req_id_q;
	logic [31:0]        now_q;
	logic [CW-1:0]      count_q;
	logic [5:0]         nrep_q;
	logic [CW-1:0]      pos_q;
	logic               found_q;

	logic [CAPACITY-1:0]       c_valid, c_aging, c_hit, c_exp, c_shift, c_load, c_pause;
	logic [ID_BITS-1:0]        c_id  [CAPACITY];
	logic [31:0]               c_expv[CAPACITY];
	logic [CAPACITY-1:0]       drop_sel, pre;
	logic                      any_hit, any_exp, do_drop, do_load, do_pause;
	logic [CW-1:0]             hit_pos, exp_pos, drop_pos, load_pos;
	logic [ID_BITS-1:0]        drop_id;
	logic [32:0]               exp_sum;
	logic [31:0]               new_exp;
	logic [ID_BITS-1:0]        load_id;
	logic [CW-1:0]             limit;

	assign exp_sum = {1'b0, now_q} + {17'd0, timeout_q};
	assign new_exp = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
	assign limit   = ({2'b00, max_q} < 8'(CAPACITY)) ? CW'(max_q) : CW'(CAPACITY);

	always_comb begin
		any_hit = 1'b0;
		any_exp = 1'b0;
		hit_pos = '0;
		exp_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (c_hit[i]) begin
				any_hit = 1'b1;
				hit_pos = CW'(i);
			end
			if (c_exp[i]) begin
				any_exp = 1'b1;
				exp_pos = CW'(i);
			end
		end
	end

	// drop decided in APPLY or SWEEP; pause and load only in APPLY
	always_comb begin
		do_drop  = 1'b0;
		do_pause = 1'b0;
		do_load  = 1'b0;
		drop_pos = pos_q;
		load_pos = count_q;
		if (state_q == S_APPLY) begin
			case (mode_q)
				citt_pkg::MODE_ADD: begin
					do_drop = found_q;
					do_load = found_q || (count_q < limit);
					load_pos = found_q ? count_q - CW'(1) : count_q;
				end
				citt_pkg::MODE_REMOVE: do_drop = found_q;
				citt_pkg::MODE_PAUSE:  do_pause = found_q;
				default: ;
			endcase
		end else if (state_q == S_SWEEP) begin
			do_drop  = any_exp && (nrep_q < 6'd32);
			drop_pos = exp_pos;
		end
	end

	assign load_id = key_q;
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			drop_sel[i] = do_drop && (CW'(i) == drop_pos);
			pre[i]      = do_drop && (CW'(i) >= drop_pos);
			c_shift[i]  = pre[i];
			c_load[i]   = do_load && (CW'(i) == load_pos);
			c_pause[i]  = do_pause && (CW'(i) == pos_q);
		end
	end

	always_comb begin
		drop_id = '0;
		for (int i = 0; i < CAPACITY; i++)
			if (drop_sel[i]) drop_id = c_id[i];
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic               nv, na;
		logic [ID_BITS-1:0] ni;
		logic [31:0]        ne;
		if (g == CAPACITY - 1) begin : g_end
			assign nv = 1'b0;
			assign na = 1'b0;
			assign ni = c_id[g];
			assign ne = c_expv[g];
		end else begin : g_mid
			assign nv = c_valid[g+1];
			assign na = c_aging[g+1];
			assign ni = c_id[g+1];
			assign ne = c_expv[g+1];
		end
		citt_cell #(.ID_BITS(ID_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.shift(c_shift[g]), .load(c_load[g]), .pause(c_pause[g]),
			.load_id(load_id), .load_exp(new_exp),
			.nxt_valid(nv), .nxt_aging(na), .nxt_id(ni), .nxt_exp(ne),
			.key(key_q), .now(now_q),
			.valid(c_valid[g]), .aging(c_aging[g]), .id(c_id[g]), .expiry(c_expv[g]),
			.hit(c_hit[g]), .expired(c_exp[g])
		);
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			timeout_q <= 16'd60;
			max_q     <= 6'd32;
			count_q   <= '0;
			done      <= 1'b0;
			last      <= 1'b0;
			status    <= citt_pkg::ST_ADDED;
			result_id <= '0;
			occupancy <= '0;
			nrep_q    <= '0;
			found_q   <= 1'b0;
			pos_q     <= '0;
			mode_q    <= citt_pkg::MODE_ADD;
			key_q     <= '0;
			req_id_q  <= '0;
			now_q     <= '0;
		end else begin
			done <= 1'b0;
			last <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == citt_pkg::REG_TIMEOUT) timeout_q <= cfg_data;
				else max_q <= cfg_data[5:0];
			end
			case (state_q)
				S_IDLE: if (start) begin
					mode_q   <= mode;
					key_q    <= ID_BITS'(conn_id);
					req_id_q <= 16'(ID_BITS'(conn_id));
					now_q    <= now_seconds;
					nrep_q   <= '0;
					state_q  <= (mode == citt_pkg::MODE_SWEEP) ? S_SWEEP : S_FIND;
				end
				S_FIND: begin
					found_q <= any_hit;
					pos_q   <= hit_pos;
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					done      <= 1'b1;
					last      <= 1'b1;
					result_id <= req_id_q;
					state_q   <= S_IDLE;
					occupancy <= 6'(count_q);
					case (mode_q)
						citt_pkg::MODE_ADD: begin
							if (found_q) status <= citt_pkg::ST_REFRESH;
							else if (count_q < limit) begin
								status    <= citt_pkg::ST_ADDED;
								count_q   <= count_q + CW'(1);
								occupancy <= 6'(count_q + CW'(1));
							end else status <= citt_pkg::ST_FULL;
						end
						citt_pkg::MODE_REMOVE: begin
							if (found_q) begin
								status    <= citt_pkg::ST_DONE;
								count_q   <= count_q - CW'(1);
								occupancy <= 6'(count_q - CW'(1));
							end else status <= citt_pkg::ST_ABSENT;
						end
						default: status <= found_q ? citt_pkg::ST_DONE : citt_pkg::ST_ABSENT;
					endcase
				end
				S_SWEEP: begin
					if (do_drop) begin
						status    <= citt_pkg::ST_EXPIRED;
						result_id <= 16'(drop_id);
						count_q   <= count_q - CW'(1);
						occupancy <= 6'(count_q - CW'(1));
						nrep_q    <= nrep_q + 6'd1;
						state_q   <= S_EMIT;
					end else if (nrep_q == '0) begin
						done      <= 1'b1;
						last      <= 1'b1;
						status    <= citt_pkg::ST_NONE;
						result_id <= req_id_q;
						occupancy <= 6'(count_q);
						state_q   <= S_IDLE;
					end else state_q <= S_IDLE;
				end
				S_EMIT: begin
					done    <= 1'b1;
					// last when no further expired entry can be taken
					last    <= !(any_exp && (nrep_q < 6'd32));
					state_q <= (any_exp && (nrep_q < 6'd32)) ? S_SWEEP : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/citt_cell.sv =====
// ----------------------------------------------------------------------------
// citt_cell
// One position of the arrival-ordered queue. Entries compact toward the
// head; a cell takes its neighbor's contents when it or a cell before it
// is dropped, and loads a new entry when it is the first free cell.
// ----------------------------------------------------------------------------
module citt_cell #(
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,     // take contents of next cell
	input  logic               load,      // write new entry
	input  logic               pause,     // clear aging flag
	input  logic [ID_BITS-1:0] load_id,
	input  logic [31:0]        load_exp,
	input  logic               nxt_valid,
	input  logic               nxt_aging,
	input  logic [ID_BITS-1:0] nxt_id,
	input  logic [31:0]        nxt_exp,
	input  logic [ID_BITS-1:0] key,
	input  logic [31:0]        now,
	output logic               valid,
	output logic               aging,
	output logic [ID_BITS-1:0] id,
	output logic [31:0]        expiry,
	output logic               hit,
	output logic               expired
);
	logic               valid_q, aging_q;
	logic [ID_BITS-1:0] id_q;
	logic [31:0]        exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			aging_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			aging_q <= 1'b1;
		end else if (shift) begin
			valid_q <= nxt_valid;
			aging_q <= nxt_aging;
		end else if (pause) begin
			aging_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q  <= load_id;
			exp_q <= load_exp;
		end else if (shift) begin
			id_q  <= nxt_id;
			exp_q <= nxt_exp;
		end
	end

	assign valid   = valid_q;
	assign aging   = aging_q;
	assign id      = id_q;
	assign expiry  = exp_q;
	assign hit     = valid_q && (id_q == key);
	assign expired = valid_q && aging_q && (exp_q < now);
endmodule

// ===== sv/citt_checker.sv =====
// ----------------------------------------------------------------------------
// citt_checker
// Port-level checks of the connection aging table, bound to the top level.
// ----------------------------------------------------------------------------
`include "connection_idle_timeout_table_unit_macros.svh"
module citt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       last,
	input logic [2:0] status,
	input logic [5:0] occupancy
);
	`CITT_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "no busy after start")
	`CITT_ASSERT_IMP(a_last_done, clk, arst_n, last, done, "last without result")
	`CITT_ASSERT_IMP(a_occ_range, clk, arst_n, done, occupancy <= 6'd32, "occupancy range")
	`CITT_ASSERT_IMP(a_none_last, clk, arst_n, done && status == citt_pkg::ST_NONE, last, "none")
endmodule

bind connection_idle_timeout_table_unit citt_checker u_citt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.last(last), .status(status), .occupancy(occupancy)
);
